>>> src/gdr_pkg.sv
`default_nettype none

package gdr_pkg;

  // Default sizes handed to the top level.
  localparam int SLOTS_DEF        = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Divider datapath widths: numerator shift register and remainder.
  localparam int DIV_NW = 58;
  localparam int DIV_RW = 25;

  // Step counts of the three divider passes.
  localparam logic [5:0] DIV_STEPS_MOD   = 6'd34;
  localparam logic [5:0] DIV_STEPS_PHASE = 6'd32;
  localparam logic [5:0] DIV_STEPS_PULSE = 6'd46;

  // Register values after reset.
  localparam logic [23:0] FULL_TURN_RST = 24'd8650000;
  localparam logic [15:0] SPU_RST       = 16'd1000;
  localparam logic [7:0]  CPS_RST       = 8'd3;
  localparam logic [25:0] NULL_RST      = 26'd0;
  localparam logic [11:0] CENTER_RST    = 12'd1425;
  localparam logic [9:0]  GAIN_RST      = 10'd300;
  localparam logic [15:0] ARRIVE_RST    = 16'd25;

  // Angles are held in 2^-32 turn.
  localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;

  // Kinds of input request.
  localparam logic [1:0] KIND_GYRO     = 2'd0;
  localparam logic [1:0] KIND_EDGE     = 2'd1;
  localparam logic [1:0] KIND_WAYPOINT = 2'd2;

  typedef enum logic [2:0] {
    CFG_FULL_TURN,
    CFG_SAMPLES_PER_UPDATE,
    CFG_CLICKS_PER_STEP,
    CFG_RATE_NULL,
    CFG_CALIBRATING,
    CFG_STEER_CENTER,
    CFG_STEER_GAIN,
    CFG_ARRIVAL_DISTANCE
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         rate_sample;
    logic [3:0]         waypoint_slot;
    logic signed [31:0] waypoint_east;
    logic signed [31:0] waypoint_north;
  } item_t;

  typedef struct packed {
    logic [11:0]        steer_pulse;
    logic signed [31:0] heading_now;
    logic signed [31:0] position_east;
    logic signed [31:0] position_north;
    logic [3:0]         target_index;
    logic               route_done;
    logic               heading_updated;
    logic               nav_updated;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [5:0]        steps;
    logic [DIV_RW-1:0] rem_init;
    logic [DIV_NW-1:0] num;
    logic [DIV_RW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_RW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HSUM,
    ST_HWRAP_HI,
    ST_HWRAP_LO,
    ST_NSUM,
    ST_MOD,
    ST_MODW,
    ST_PH,
    ST_PHW,
    ST_SC,
    ST_SCOUT,
    ST_POS,
    ST_DIFF,
    ST_ABS,
    ST_MAX,
    ST_NORM,
    ST_BQ,
    ST_BC,
    ST_TMUL,
    ST_TGT,
    ST_HDIFF,
    ST_WRAP_LO,
    ST_WRAP_HI,
    ST_PMUL,
    ST_PDIV,
    ST_PDIVW,
    ST_PULSE,
    ST_OUT
  } state_t;

  // Arc tangent of 2^-i in 2^-32 turn.
  function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/gdr_ifs.sv
`default_nettype none

// Input request channel.
interface gdr_item_if;
  logic          valid;
  logic          ready;
  gdr_pkg::item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// Result channel.
interface gdr_result_if;
  logic            valid;
  logic            ready;
  gdr_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// Register write channel.
interface gdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/gdr_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The remainder may be
// preloaded so that the same unit yields fractional quotients.
module gdr_div (
  input  logic              clk,
  input  logic              rst,
  input  gdr_pkg::div_req_t req,
  output gdr_pkg::div_rsp_t rsp
);

  logic                      busy;
  logic                      done;
  logic [5:0]                cnt;
  logic [gdr_pkg::DIV_RW-1:0] rem;
  logic [gdr_pkg::DIV_RW-1:0] dvs;
  logic [gdr_pkg::DIV_NW-1:0] num;
  logic [gdr_pkg::DIV_NW-1:0] quo;
  logic [gdr_pkg::DIV_RW+1:0] trial;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {1'b0, rem, num[gdr_pkg::DIV_NW-1]} - {2'b00, dvs};

  // Sequencing of a pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, numerator and quotient shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      num <= req.num;
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      num <= {num[gdr_pkg::DIV_NW-2:0], 1'b0};
      if (!trial[gdr_pkg::DIV_RW+1]) begin
        rem <= trial[gdr_pkg::DIV_RW-1:0];
        quo <= {quo[gdr_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem <= {rem[gdr_pkg::DIV_RW-2:0], num[gdr_pkg::DIV_NW-1]};
        quo <= {quo[gdr_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

>>> src/gyro_dead_reckoning_waypoint_steer_top.sv
`default_nettype none

// Dead-reckoning waypoint steering. Each request (gyro sample, encoder edge
// or waypoint write) yields exactly one result showing the state after it;
// the block takes one request at a time. A navigation update runs a
// sequencer around one shared restoring divider and a CORDIC rotator,
// with up to forty normalising shifts of the waypoint vector (none when
// the vector is zero) and the divider's three passes of 34, 32 and 46
// steps (phase modulo, phase fraction and pulse scaling). Registers may
// be written at any time the block holds no request.
module gyro_dead_reckoning_waypoint_steer_top #(
  parameter int WAYPOINT_SLOTS = gdr_pkg::SLOTS_DEF,
  parameter int CORDIC_STEPS   = gdr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  gdr_cfg_if.sink             cfg,
  gdr_item_if.sink            item,
  gdr_result_if.source        result
);

  localparam int TW = $clog2(WAYPOINT_SLOTS);
  localparam logic [4:0]  STEP_LAST  = 5'(CORDIC_STEPS - 1);
  localparam logic [41:0] NORM_LIMIT = 42'd1 << 40;

  gdr_pkg::state_t state, state_next;

  // Configuration registers.
  logic [23:0] full_turn;
  logic [15:0] samples_per_update;
  logic [7:0]  clicks_per_step;
  logic [25:0] rate_null;
  logic        calibrating;
  logic [11:0] steer_center;
  logic [9:0]  steer_gain;
  logic [15:0] arrival_distance;

  // Architectural state.
  logic [25:0]        rate_sum;
  logic [15:0]        sample_count;
  logic [7:0]         edge_count;
  logic signed [31:0] heading;
  logic signed [31:0] prev_heading;
  logic signed [31:0] pos_east;
  logic signed [31:0] pos_north;
  logic [TW-1:0]      target;
  logic               done_flag;
  logic [11:0]        steer_hold;
  logic               hupd;
  logic               nupd;
  logic               out_valid;
  gdr_pkg::result_t   out_data;

  // Waypoint store, east in the upper half.
  logic [63:0] wp_mem [WAYPOINT_SLOTS];
  logic [63:0] wp_rd;

  // Working registers of the sequencer.
  logic signed [33:0] hacc;
  logic signed [33:0] hsum;
  logic [24:0]        r_mod;
  logic signed [33:0] sc_x, sc_y, sc_z;
  logic               sc_neg;
  logic [4:0]         iter;
  logic signed [33:0] sval, cval;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [33:0]        prox;
  logic [41:0]        mag;
  logic signed [44:0] bx, by;
  logic signed [33:0] bz;
  logic signed [58:0] tprod;
  logic signed [33:0] target_h;
  logic signed [33:0] diff;
  logic               dsign;
  logic [45:0]        pprod;

  gdr_pkg::div_req_t div_req;
  gdr_pkg::div_rsp_t div_rsp;

  // Derived values.
  logic               acc;
  logic               cfg_acc;
  logic [15:0]        cnt_inc;
  logic [7:0]         edge_inc;
  logic [23:0]        ftu;
  logic [24:0]        ftu2;
  logic signed [33:0] f34;
  logic signed [33:0] half34;
  logic signed [33:0] hfin;
  logic [33:0]        habs;
  logic [31:0]        phase;
  logic signed [33:0] zp;
  logic signed [33:0] at;
  logic signed [33:0] sc_xs, sc_ys;
  logic signed [44:0] bxs, bys;
  logic [32:0]        max_ad;
  logic signed [33:0] adiff;
  logic signed [47:0] pv;
  logic [TW+3:0]      slot_wide;
  logic [TW+3:0]      tgt_wide;
  logic               slot_ok;

  gdr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign acc      = item.valid & item.ready;
  assign cfg_acc  = cfg.valid & cfg.ready;
  assign cnt_inc  = sample_count + 16'd1;
  assign edge_inc = edge_count + 8'd1;
  assign ftu      = (full_turn == 24'd0) ? 24'd1 : full_turn;
  assign ftu2     = {ftu, 1'b0};
  assign f34      = $signed({10'b0, ftu});
  assign half34   = $signed({11'b0, ftu[23:1]});
  assign hfin     = (hacc < 34'sd0 && !calibrating) ? hacc + f34 : hacc;
  assign habs     = hsum[33] ? 34'(-hsum) : hsum;
  assign phase    = div_rsp.quo[31:0];
  assign zp       = $signed({{2{phase[31]}}, phase});
  assign at       = gdr_pkg::atan_turn(iter);
  assign sc_xs    = sc_x >>> iter;
  assign sc_ys    = sc_y >>> iter;
  assign bxs      = bx >>> iter;
  assign bys      = by >>> iter;
  assign max_ad   = (adx > ady) ? adx : ady;
  assign adiff    = diff[33] ? -diff : diff;
  assign pv       = dsign ? $signed({36'b0, steer_center}) - $signed({2'b0, div_rsp.quo[45:0]})
                          : $signed({36'b0, steer_center}) + $signed({2'b0, div_rsp.quo[45:0]});
  assign slot_wide = {{TW{1'b0}}, item.data.waypoint_slot};
  assign tgt_wide  = {4'b0, target};
  assign slot_ok   = (32'(item.data.waypoint_slot) < WAYPOINT_SLOTS);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gdr_pkg::ST_IDLE: begin
        if (acc) begin
          state_next = gdr_pkg::ST_OUT;
          if (item.data.kind == gdr_pkg::KIND_GYRO && cnt_inc >= samples_per_update) begin
            state_next = gdr_pkg::ST_HSUM;
          end else if (item.data.kind == gdr_pkg::KIND_EDGE && edge_inc >= clicks_per_step) begin
            state_next = gdr_pkg::ST_NSUM;
          end
        end
      end
      gdr_pkg::ST_HSUM:     state_next = gdr_pkg::ST_HWRAP_HI;
      gdr_pkg::ST_HWRAP_HI: state_next = gdr_pkg::ST_HWRAP_LO;
      gdr_pkg::ST_HWRAP_LO: state_next = gdr_pkg::ST_OUT;
      gdr_pkg::ST_NSUM:     state_next = gdr_pkg::ST_MOD;
      gdr_pkg::ST_MOD:      state_next = gdr_pkg::ST_MODW;
      gdr_pkg::ST_MODW: begin
        if (div_rsp.done) state_next = gdr_pkg::ST_PH;
      end
      gdr_pkg::ST_PH:       state_next = gdr_pkg::ST_PHW;
      gdr_pkg::ST_PHW: begin
        if (div_rsp.done) state_next = gdr_pkg::ST_SC;
      end
      gdr_pkg::ST_SC: begin
        if (iter == STEP_LAST) state_next = gdr_pkg::ST_SCOUT;
      end
      gdr_pkg::ST_SCOUT:    state_next = gdr_pkg::ST_POS;
      gdr_pkg::ST_POS:      state_next = gdr_pkg::ST_DIFF;
      gdr_pkg::ST_DIFF:     state_next = gdr_pkg::ST_ABS;
      gdr_pkg::ST_ABS:      state_next = gdr_pkg::ST_MAX;
      gdr_pkg::ST_MAX:      state_next = gdr_pkg::ST_NORM;
      gdr_pkg::ST_NORM: begin
        if (mag == 42'd0) begin
          state_next = gdr_pkg::ST_TMUL;
        end else if (mag >= NORM_LIMIT) begin
          state_next = gdr_pkg::ST_BQ;
        end
      end
      gdr_pkg::ST_BQ:       state_next = gdr_pkg::ST_BC;
      gdr_pkg::ST_BC: begin
        if (iter == STEP_LAST) state_next = gdr_pkg::ST_TMUL;
      end
      gdr_pkg::ST_TMUL:     state_next = gdr_pkg::ST_TGT;
      gdr_pkg::ST_TGT:      state_next = gdr_pkg::ST_HDIFF;
      gdr_pkg::ST_HDIFF:    state_next = gdr_pkg::ST_WRAP_LO;
      gdr_pkg::ST_WRAP_LO:  state_next = gdr_pkg::ST_WRAP_HI;
      gdr_pkg::ST_WRAP_HI:  state_next = gdr_pkg::ST_PMUL;
      gdr_pkg::ST_PMUL:     state_next = gdr_pkg::ST_PDIV;
      gdr_pkg::ST_PDIV:     state_next = gdr_pkg::ST_PDIVW;
      gdr_pkg::ST_PDIVW: begin
        if (div_rsp.done) state_next = gdr_pkg::ST_PULSE;
      end
      gdr_pkg::ST_PULSE:    state_next = gdr_pkg::ST_OUT;
      gdr_pkg::ST_OUT: begin
        if (!out_valid || result.ready) state_next = gdr_pkg::ST_IDLE;
      end
      default:              state_next = gdr_pkg::ST_IDLE;
    endcase
  end

  // Handshake and divider requests.
  always_comb begin
    item.ready = (state == gdr_pkg::ST_IDLE) && !rst;
    div_req    = '0;
    case (state)
      gdr_pkg::ST_MOD: begin
        div_req.start   = 1'b1;
        div_req.steps   = gdr_pkg::DIV_STEPS_MOD;
        div_req.num     = {habs, 24'b0};
        div_req.divisor = ftu2;
      end
      gdr_pkg::ST_PH: begin
        div_req.start    = 1'b1;
        div_req.steps    = gdr_pkg::DIV_STEPS_PHASE;
        div_req.rem_init = r_mod;
        div_req.divisor  = ftu2;
      end
      gdr_pkg::ST_PDIV: begin
        div_req.start   = 1'b1;
        div_req.steps   = gdr_pkg::DIV_STEPS_PULSE;
        div_req.num     = {pprod, 12'b0};
        div_req.divisor = {1'b0, ftu};
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  assign cfg.ready    = !rst;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Control state, registers and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= gdr_pkg::ST_IDLE;
      full_turn          <= gdr_pkg::FULL_TURN_RST;
      samples_per_update <= gdr_pkg::SPU_RST;
      clicks_per_step    <= gdr_pkg::CPS_RST;
      rate_null          <= gdr_pkg::NULL_RST;
      calibrating        <= 1'b0;
      steer_center       <= gdr_pkg::CENTER_RST;
      steer_gain         <= gdr_pkg::GAIN_RST;
      arrival_distance   <= gdr_pkg::ARRIVE_RST;
      rate_sum           <= '0;
      sample_count       <= '0;
      edge_count         <= '0;
      heading            <= '0;
      prev_heading       <= '0;
      pos_east           <= '0;
      pos_north          <= '0;
      target             <= '0;
      done_flag          <= 1'b0;
      steer_hold         <= gdr_pkg::CENTER_RST;
      hupd               <= 1'b0;
      nupd               <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes.
      if (cfg_acc) begin
        case (gdr_pkg::cfg_reg_t'(cfg.index))
          gdr_pkg::CFG_FULL_TURN:          full_turn          <= cfg.data[23:0];
          gdr_pkg::CFG_SAMPLES_PER_UPDATE: samples_per_update <= cfg.data[15:0];
          gdr_pkg::CFG_CLICKS_PER_STEP:    clicks_per_step    <= cfg.data[7:0];
          gdr_pkg::CFG_RATE_NULL:          rate_null          <= cfg.data[25:0];
          gdr_pkg::CFG_CALIBRATING:        calibrating        <= cfg.data[0];
          gdr_pkg::CFG_STEER_CENTER:       steer_center       <= cfg.data[11:0];
          gdr_pkg::CFG_STEER_GAIN:         steer_gain         <= cfg.data[9:0];
          gdr_pkg::CFG_ARRIVAL_DISTANCE:   arrival_distance   <= cfg.data[15:0];
          default:                         steer_gain         <= steer_gain;
        endcase
      end

      // Counting at request acceptance.
      if (acc) begin
        hupd <= 1'b0;
        nupd <= 1'b0;
        if (item.data.kind == gdr_pkg::KIND_GYRO) begin
          rate_sum     <= rate_sum + {16'b0, item.data.rate_sample};
          sample_count <= cnt_inc;
        end else if (item.data.kind == gdr_pkg::KIND_EDGE) begin
          edge_count <= (edge_inc >= clicks_per_step) ? 8'd0 : edge_inc;
        end
      end

      // Heading update closes the summing window.
      if (state == gdr_pkg::ST_HWRAP_LO) begin
        heading      <= hfin[31:0];
        rate_sum     <= '0;
        sample_count <= '0;
        hupd         <= 1'b1;
      end

      // Unit step along the mean heading.
      if (state == gdr_pkg::ST_POS) begin
        pos_east     <= pos_east + sval[31:0];
        pos_north    <= pos_north + cval[31:0];
        prev_heading <= heading;
      end

      // Saturated pulse and waypoint arrival.
      if (state == gdr_pkg::ST_PULSE) begin
        nupd <= 1'b1;
        if (pv < 48'sd0) begin
          steer_hold <= 12'd0;
        end else if (pv > 48'sd4095) begin
          steer_hold <= 12'd4095;
        end else begin
          steer_hold <= pv[11:0];
        end
        if (prox < {2'b0, arrival_distance, 16'b0}) begin
          if (32'(target) + 32'd1 < WAYPOINT_SLOTS) begin
            target <= target + TW'(1);
          end else begin
            done_flag <= 1'b1;
          end
        end
      end

      // Result register.
      if (state == gdr_pkg::ST_OUT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Waypoint store with registered read of the current target.
  always_ff @(posedge clk) begin
    if (acc && item.data.kind == gdr_pkg::KIND_WAYPOINT && slot_ok) begin
      wp_mem[slot_wide[TW-1:0]] <= {item.data.waypoint_east, item.data.waypoint_north};
    end
    wp_rd <= wp_mem[target];
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      gdr_pkg::ST_HSUM: begin
        hacc <= $signed({{2{heading[31]}}, heading}) + $signed({8'b0, rate_sum})
                - $signed({8'b0, rate_null});
      end
      gdr_pkg::ST_HWRAP_HI: begin
        if (hacc > f34 && !calibrating) hacc <= hacc - f34;
      end
      gdr_pkg::ST_NSUM: begin
        hsum <= $signed({{2{heading[31]}}, heading})
                + $signed({{2{prev_heading[31]}}, prev_heading});
      end
      gdr_pkg::ST_MODW: begin
        if (div_rsp.done) begin
          r_mod <= (hsum[33] && div_rsp.rem != 25'd0) ? ftu2 - div_rsp.rem : div_rsp.rem;
        end
      end
      gdr_pkg::ST_PHW: begin
        // Fold the phase into the right half plane.
        iter <= '0;
        sc_x <= gdr_pkg::CORDIC_K;
        sc_y <= '0;
        if (zp > gdr_pkg::QUARTER_TURN) begin
          sc_z   <= zp - gdr_pkg::HALF_TURN;
          sc_neg <= 1'b1;
        end else if (zp < -gdr_pkg::QUARTER_TURN) begin
          sc_z   <= zp + gdr_pkg::HALF_TURN;
          sc_neg <= 1'b1;
        end else begin
          sc_z   <= zp;
          sc_neg <= 1'b0;
        end
      end
      gdr_pkg::ST_SC: begin
        iter <= iter + 5'd1;
        if (!sc_z[33]) begin
          sc_x <= sc_x - sc_ys;
          sc_y <= sc_y + sc_xs;
          sc_z <= sc_z - at;
        end else begin
          sc_x <= sc_x + sc_ys;
          sc_y <= sc_y - sc_xs;
          sc_z <= sc_z + at;
        end
      end
      gdr_pkg::ST_SCOUT: begin
        // Undo the fold and round to Q16.16.
        sval <= (sc_neg ? (34'sd8192 - sc_y) : (sc_y + 34'sd8192)) >>> 14;
        cval <= (sc_neg ? (34'sd8192 - sc_x) : (sc_x + 34'sd8192)) >>> 14;
      end
      gdr_pkg::ST_DIFF: begin
        dx <= $signed({wp_rd[63], wp_rd[63:32]}) - $signed({pos_east[31], pos_east});
        dy <= $signed({wp_rd[31], wp_rd[31:0]}) - $signed({pos_north[31], pos_north});
      end
      gdr_pkg::ST_ABS: begin
        adx <= dx[32] ? 33'(-dx) : dx;
        ady <= dy[32] ? 33'(-dy) : dy;
        bx  <= $signed({{12{dy[32]}}, dy});
        by  <= $signed({{12{dx[32]}}, dx});
      end
      gdr_pkg::ST_MAX: begin
        mag  <= {9'b0, max_ad};
        prox <= {1'b0, adx} + {1'b0, ady};
      end
      gdr_pkg::ST_NORM: begin
        if (mag == 42'd0) begin
          bz <= '0;
        end else if (mag < NORM_LIMIT) begin
          mag <= {mag[40:0], 1'b0};
          bx  <= bx <<< 1;
          by  <= by <<< 1;
        end
      end
      gdr_pkg::ST_BQ: begin
        iter <= '0;
        if (bx < 45'sd0) begin
          bz <= (by >= 45'sd0) ? gdr_pkg::HALF_TURN : -gdr_pkg::HALF_TURN;
          bx <= -bx;
          by <= -by;
        end else begin
          bz <= '0;
        end
      end
      gdr_pkg::ST_BC: begin
        iter <= iter + 5'd1;
        if (by < 45'sd0) begin
          bx <= bx - bys;
          by <= by + bxs;
          bz <= bz - at;
        end else begin
          bx <= bx + bys;
          by <= by - bxs;
          bz <= bz + at;
        end
      end
      gdr_pkg::ST_TMUL: begin
        tprod <= bz * $signed({1'b0, ftu});
      end
      gdr_pkg::ST_TGT: begin
        // Scale to heading units, truncating toward zero.
        target_h <= 34'((tprod + (tprod[58] ? 59'sd4294967295 : 59'sd0)) >>> 32);
      end
      gdr_pkg::ST_HDIFF: begin
        diff <= target_h - $signed({{2{heading[31]}}, heading});
      end
      gdr_pkg::ST_WRAP_LO: begin
        if (diff < -half34) diff <= diff + f34;
      end
      gdr_pkg::ST_WRAP_HI: begin
        if (diff > half34) diff <= diff - f34;
      end
      gdr_pkg::ST_PMUL: begin
        dsign <= diff[33];
        pprod <= {13'b0, adiff[32:0]} * {34'b0, steer_gain, 2'b00};
      end
      gdr_pkg::ST_OUT: begin
        if (!out_valid || result.ready) begin
          out_data.steer_pulse     <= steer_hold;
          out_data.heading_now     <= heading;
          out_data.position_east   <= pos_east;
          out_data.position_north  <= pos_north;
          out_data.target_index    <= tgt_wide[3:0];
          out_data.route_done      <= done_flag;
          out_data.heading_updated <= hupd;
          out_data.nav_updated     <= nupd;
        end
      end
      default: begin
        hacc <= hacc;
      end
    endcase
  end

endmodule

`default_nettype wire
